### src/pid_controller_step_assert.svh
// Assertion helpers shared by the controller RTL.
// Both forms sample on clk_i and are held off while rst_ni is low.
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// Same-cycle implication.
`define PIDCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pidcs assertion failed");

// Next-cycle implication.
`define PIDCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pidcs assertion failed");

`endif

### src/pidcs_pkg.sv
`timescale 1ns / 1ps
package pidcs_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int GAIN_WIDTH = 24;

  // Derived widths
  localparam int DIFF_W     = DATA_WIDTH + 1;
  localparam int GAIN_S_W   = GAIN_WIDTH + 1;
  localparam int PROD_W     = GAIN_S_W + DIFF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int INT_W      = DATA_WIDTH + FRAC_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH;

  localparam int OUT_MAX_RESET = 255;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [GAIN_WIDTH-1:0] gain_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_POM,
    REG_REV,
    REG_OUT_MIN,
    REG_OUT_MAX
  } cfg_reg_e;

  typedef struct packed {
    data_t measured;
    data_t setpoint;
    logic  auto_mode;
    data_t manual_output;
  } in_item_t;

  typedef struct packed {
    data_t drive;
    logic  computed;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

### src/pidcs_if.sv
`timescale 1ns / 1ps
// Sample channel into the controller.
interface pidcs_in_if;
  import pidcs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// Result channel out of the controller.
interface pidcs_out_if;
  import pidcs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// Register write channel.
interface pidcs_cfg_if;
  import pidcs_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### src/pid_controller_step.sv
`timescale 1ns / 1ps
// PID controller step with anti-windup clamping and bumpless manual-to-auto
// transfer. Each item on in_i is one sample period; each produces exactly one
// item on out_o, in order. The block sustains one item per clock cycle while
// out_o is not stalled; the input stage forms error and measurement change
// and runs the three gain multipliers (17 x 25 bits), and the result stage
// closes the integral loop (add, clamp to the limits scaled by 2^FRAC_BITS)
// and forms the clamped drive. The integral register is read and written in
// the result stage alone, so consecutive samples need no bubble. Gains are
// unsigned with FRAC_BITS fraction bits; the drive is floored by an
// arithmetic shift. In manual mode manual_output passes through with
// computed = 0 and the integral and last measurement hold. Write registers
// only while no item is in flight; register writes are taken every cycle.
`include "pid_controller_step_assert.svh"

module pid_controller_step (
  input  logic clk_i,
  input  logic rst_ni,
  pidcs_in_if.sink    in_i,
  pidcs_out_if.source out_o,
  pidcs_cfg_if.sink   cfg_i
);
  import pidcs_pkg::*;

  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [GAIN_S_W-1:0] sgain_t;

  // Input-stage register contents
  typedef struct packed {
    logic  auto_mode;
    logic  enter;
    logic  pom;
    data_t manual;
    prod_t ip;   // ki * error
    prod_t pp;   // kp * (error or measurement change)
    prod_t dp;   // kd * measurement change
  } s1_t;

  // hi is tested first, so with inverted limits x > hi gives hi, else lo.
  function automatic data_t clamp_data(data_t x, data_t lo, data_t hi);
    data_t r;
    r = x;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end
    return r;
  endfunction

  function automatic acc_t clamp_acc(acc_t x, acc_t lo, acc_t hi);
    acc_t r;
    r = x;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end
    return r;
  endfunction

  function automatic sgain_t apply_dir(gain_t k, logic rev);
    sgain_t g;
    g = $signed({1'b0, k});
    return rev ? -g : g;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  gain_t kp_q, ki_q, kd_q;
  logic  pom_q, rev_q;
  data_t out_min_q, out_max_q;
  data_t cfg_data;

  assign cfg_i.ready = 1'b1;
  assign cfg_data    = $signed(cfg_i.item.data[DATA_WIDTH-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      pom_q     <= 1'b0;
      rev_q     <= 1'b0;
      out_min_q <= '0;
      out_max_q <= DATA_WIDTH'(OUT_MAX_RESET);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.item.index))
        REG_KP:      kp_q      <= cfg_i.item.data[GAIN_WIDTH-1:0];
        REG_KI:      ki_q      <= cfg_i.item.data[GAIN_WIDTH-1:0];
        REG_KD:      kd_q      <= cfg_i.item.data[GAIN_WIDTH-1:0];
        REG_POM:     pom_q     <= cfg_i.item.data[0];
        REG_REV:     rev_q     <= cfg_i.item.data[0];
        REG_OUT_MIN: out_min_q <= cfg_data;
        REG_OUT_MAX: out_max_q <= cfg_data;
        default: ;   // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the input stage advances whenever the result register is free
  // or being emptied this cycle.
  // ---------------------------------------------------------------------------
  logic s1_v_q, out_v_q;
  logic s2_adv, in_acc;

  assign s2_adv     = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || s2_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Input stage: error, measurement change, gain products
  // ---------------------------------------------------------------------------
  logic   was_auto_q;
  data_t  last_meas_q;
  logic   enter_c;
  diff_t  err_c, dmeas_c, psel_c;
  sgain_t gp_c, gi_c, gd_c;
  s1_t    s1_d, s1_q;

  always_comb begin
    enter_c = in_i.item.auto_mode && !was_auto_q;
    err_c   = DIFF_W'(in_i.item.setpoint) - DIFF_W'(in_i.item.measured);
    // Entering automatic re-seeds the last measurement, so the change is zero.
    dmeas_c = enter_c ? '0 : (DIFF_W'(in_i.item.measured) - DIFF_W'(last_meas_q));
    psel_c  = pom_q ? dmeas_c : err_c;
    gp_c    = apply_dir(kp_q, rev_q);
    gi_c    = apply_dir(ki_q, rev_q);
    gd_c    = apply_dir(kd_q, rev_q);

    s1_d.auto_mode = in_i.item.auto_mode;
    s1_d.enter     = enter_c;
    s1_d.pom       = pom_q;
    s1_d.manual    = in_i.item.manual_output;
    s1_d.ip        = gi_c * err_c;
    s1_d.pp        = gp_c * psel_c;
    s1_d.dp        = gd_c * dmeas_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      was_auto_q  <= 1'b0;
      last_meas_q <= '0;
    end else begin
      if (in_acc) begin
        s1_v_q     <= 1'b1;
        was_auto_q <= in_i.item.auto_mode;
        // Manual samples leave the last measurement alone.
        if (in_i.item.auto_mode) begin
          last_meas_q <= in_i.item.measured;
        end
      end else if (s2_adv) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  // Payload register: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: integral loop and drive
  // ---------------------------------------------------------------------------
  logic signed [INT_W-1:0] integ_q;
  acc_t      lo_acc, hi_acc, base_c, isum_c, iclamp_c, acc_c, shift_c;
  data_t     seed_c, drive_c;
  out_item_t out_d, out_q;

  always_comb begin
    lo_acc   = ACC_W'(out_min_q) <<< FRAC_BITS;
    hi_acc   = ACC_W'(out_max_q) <<< FRAC_BITS;
    // Bumpless entry: start from the clamped manual output.
    seed_c   = clamp_data(s1_q.manual, out_min_q, out_max_q);
    base_c   = s1_q.enter ? (ACC_W'(seed_c) <<< FRAC_BITS) : ACC_W'(integ_q);
    isum_c   = base_c + ACC_W'(s1_q.ip) - (s1_q.pom ? ACC_W'(s1_q.pp) : acc_t'(0));
    iclamp_c = clamp_acc(isum_c, lo_acc, hi_acc);
    acc_c    = (s1_q.pom ? acc_t'(0) : ACC_W'(s1_q.pp)) + iclamp_c - ACC_W'(s1_q.dp);
    shift_c  = acc_c >>> FRAC_BITS;
    drive_c  = DATA_WIDTH'(clamp_acc(shift_c, ACC_W'(out_min_q), ACC_W'(out_max_q)));

    if (s1_q.auto_mode) begin
      out_d.drive    = drive_c;
      out_d.computed = 1'b1;
    end else begin
      out_d.drive    = s1_q.manual;
      out_d.computed = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_adv && s1_q.auto_mode) begin
        integ_q <= INT_W'(iclamp_c);
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.item  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A stalled input stage keeps its item.
  `PIDCS_ASSERT_NEXT(a_s1_hold, s1_v_q && !s2_adv, s1_v_q && $stable(s1_q))
  // A manual sample passes its output through uncomputed.
  `PIDCS_ASSERT_NEXT(a_manual_pass, s2_adv && !s1_q.auto_mode,
                     !out_q.computed && out_q.drive == $past(s1_q.manual))
  // A computed drive lies within ordered limits.
  `PIDCS_ASSERT_NEXT(a_drive_range, s2_adv && s1_q.auto_mode && out_min_q <= out_max_q,
                     out_q.computed && out_q.drive >= $past(out_min_q) &&
                     out_q.drive <= $past(out_max_q))
  // Entering automatic sees no derivative kick.
  `PIDCS_ASSERT_NEXT(a_enter_no_kick, in_acc && enter_c, s1_q.enter && s1_q.dp == '0)

endmodule
